// ----- sv/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
// Used by skt_cell, sorted_key_table_core and skt_checker; no dependencies.
package skt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W = 32;
   localparam int NAME_LOW_W = 64;
   localparam int NAME_HIGH_W = 16;
   localparam int QTY_W = 32;
   localparam int ENTRIES_W = 7;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic {
      STATE_IDLE   = 1'b0,
      STATE_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [NAME_LOW_W-1:0]   name_low;
      logic [NAME_HIGH_W-1:0]  name_high;
      logic signed [QTY_W-1:0] quantity;
   } record_type;

   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic rem_en;
   } cell_ctl_type;

endpackage

// ----- sv/skt_cell.sv -----
// One slot of the sorted table: holds a record and its compare flags.
// Shifts records to and from its neighbors. Depends on skt_pkg.
module skt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  skt_pkg::cell_ctl_type    ctl,
   input  logic signed [31:0]       cmp_key,
   input  logic                     occupied,
   input  skt_pkg::record_type      new_rec,
   input  skt_pkg::record_type      prev_rec,
   input  logic                     prev_le,
   input  skt_pkg::record_type      next_rec,
   output skt_pkg::record_type      rec,
   output logic                     le
);
   import skt_pkg::*;

   record_type rec_ff, rec_in;
   logic       le_ff, le_in;
   logic       eq_ff, eq_in;

   always_comb begin
      le_in = le_ff;
      eq_in = eq_ff;
      if (ctl.cmp_en) begin
         le_in = occupied && (rec_ff.key <= cmp_key);
         eq_in = occupied && (rec_ff.key == cmp_key);
      end
   end

   always_comb begin
      rec_in = rec_ff;
      if (ctl.ins_en && !le_ff) begin
         rec_in = prev_le ? new_rec : prev_rec;
      end else if (ctl.rem_en && !(le_ff && !eq_ff)) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         le_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         le_ff <= le_in;
         eq_ff <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;
   assign le  = le_ff;

endmodule

// ----- sv/sorted_key_table_core.sv -----
// Sorted key table: each item passes through the accept cycle, in which every
// cell compares its key with the request key, and the update cycle, in which the
// row of cells shifts by one slot when an entry is inserted or removed; busy is
// high during the update cycle only. The result strobe comes in the cycle after
// the update and cannot be stalled. Depends on skt_pkg and skt_cell.
module sorted_key_table_core #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic signed [31:0]          req_rec_key,
   input  logic [63:0]                 req_name_low,
   input  logic [15:0]                 req_name_high,
   input  logic signed [31:0]          req_quantity,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_status,
   output logic [6:0]                  rsp_entries
);
   import skt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   state_type    state_ff, state_in;
   logic         op_ff;
   record_type   new_rec_ff;
   logic [CW-1:0] count_ff, count_in;
   logic         strobe_ff, strobe_in;
   status_type   status_ff, status_in;
   logic         accept;
   logic         full;
   logic         found;
   cell_ctl_type ctl;

   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] le_vec;
   logic [CAPACITY-1:0] eq_vec;
   record_type          rec_vec [CAPACITY];
   logic [CW+ENTRIES_W-1:0] entries_ext;

   assign accept = start && (state_ff == STATE_IDLE);
   assign full   = (count_ff == CW'(CAPACITY));

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         record_type prev_rec;
         logic       prev_le;
         record_type next_rec;

         assign occ[gi] = (CW'(gi) < count_ff);
         assign eq_vec[gi] = occ[gi] && (rec_vec[gi].key == new_rec_ff.key);

         if (gi == 0) begin : g_first
            assign prev_rec = new_rec_ff;
            assign prev_le  = 1'b1;
         end else begin : g_mid
            assign prev_rec = rec_vec[gi-1];
            assign prev_le  = le_vec[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign next_rec = rec_vec[gi];
         end else begin : g_inner
            assign next_rec = rec_vec[gi+1];
         end

         skt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .cmp_key  (req_rec_key),
            .occupied (occ[gi]),
            .new_rec  (new_rec_ff),
            .prev_rec (prev_rec),
            .prev_le  (prev_le),
            .next_rec (next_rec),
            .rec      (rec_vec[gi]),
            .le       (le_vec[gi])
         );
      end
   endgenerate

   assign found = |eq_vec;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      ctl.cmp_en = 1'b0;
      ctl.ins_en = 1'b0;
      ctl.rem_en = 1'b0;
      busy       = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               ctl.cmp_en = 1'b1;
               state_in   = STATE_UPDATE;
            end
         end
         STATE_UPDATE: begin
            busy      = 1'b1;
            strobe_in = 1'b1;
            state_in  = STATE_IDLE;
            if (op_ff == OP_INSERT) begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.ins_en = 1'b1;
                  count_in   = count_ff + CW'(1);
                  status_in  = ST_INSERTED;
               end
            end else begin
               if (found) begin
                  ctl.rem_en = 1'b1;
                  count_in   = count_ff - CW'(1);
                  status_in  = ST_REMOVED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= STATE_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= ST_INSERTED;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                <= req_op;
         new_rec_ff.key       <= req_rec_key;
         new_rec_ff.name_low  <= req_name_low;
         new_rec_ff.name_high <= req_name_high;
         new_rec_ff.quantity  <= req_quantity;
      end
   end

   assign entries_ext = {{ENTRIES_W{1'b0}}, count_ff};
   assign rsp_strobe  = strobe_ff;
   assign rsp_status  = status_ff;
   assign rsp_entries = entries_ext[ENTRIES_W-1:0];

endmodule

// ----- sv/skt_checker.sv -----
// Port-level checks for sorted_key_table_core, attached by bind.
// Depends on skt_pkg.
module skt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic [6:0]         rsp_entries
);
   import skt_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("accepted beat gave no result");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) && !busy)
      else $error("result beat without a preceding update");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_INSERTED || rsp_status == ST_FULL)
      |-> rsp_entries != 7'd0)
      else $error("insert reported an empty table");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (.*);
